FILE: hw/rtl/cpp_pkg.sv
`default_nettype none

package cpp_pkg;

    localparam int IN_W     = 96;
    localparam int OUT_W    = 64;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_W    = 58;
    localparam int DEN_W    = 36;
    localparam int DIV_BITS = 18;

    localparam int ST_DIV0  = 7;
    localparam int STAGES   = ST_DIV0 + DIV_BITS + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X,
        REG_CAMERA_Y,
        REG_CAMERA_Z,
        REG_YAW_SINE,
        REG_YAW_COSINE,
        REG_TILT_FACTOR,
        REG_PROJ_SCALE
    } cfg_idx_t;

    typedef struct packed {
        logic [DEN_W-1:0] den_mag;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             zero;
        logic [31:0]      depth;
    } div_side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/camera_point_projection.sv
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: point_x, point_y, point_z
//  m_      | out | m_tvalid/m_tready  | m_tdata: screen_x, screen_y, depth;
//          |     |                    | m_tuser: zero_depth
//  cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata
//
//  One word enters per cycle unless a stall backs up to the input (s_tready low).
//  Most of the pipeline is the 18-stage restoring divider, one quotient bit per stage.
//  Each stage holds only while the stage behind it is full and stalled, so
//  bubbles collapse and the input keeps taking words while a result waits.
//  Reset clears the valid bits and loads the register defaults.
`default_nettype none

module camera_point_projection #(
    parameter int HALF_WIDTH  = 320,
    parameter int HALF_HEIGHT = 240
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_we,
    input  wire logic [cpp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [cpp_pkg::CFG_W-1:0]      cfg_wdata,

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  wire logic [cpp_pkg::IN_W-1:0]       s_tdata,

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // screen_x [15:0], screen_y [31:16], depth [63:32]
    output logic [cpp_pkg::OUT_W-1:0]           m_tdata,
    // zero_depth [0]
    output logic [0:0]                          m_tuser
);

    localparam int NW = cpp_pkg::NUM_W;
    localparam int DW = cpp_pkg::DEN_W;
    localparam int QB = cpp_pkg::DIV_BITS;
    localparam int NS = cpp_pkg::STAGES;
    localparam int SD = cpp_pkg::ST_DIV0;

    function automatic logic [15:0] screen_sat(input logic [QB-1:0] q, input logic neg,
                                               input logic ovf, input logic [19:0] half);
        logic signed [19:0] qs;
        logic signed [19:0] sum;
        logic [15:0]        res;
        qs  = neg ? -$signed(20'(q)) : $signed(20'(q));
        sum = $signed(half) + qs;
        if (ovf) begin
            res = neg ? 16'h8000 : 16'h7FFF;
        end else if (sum[19:15] == {5{sum[19]}}) begin
            res = sum[15:0];
        end else begin
            res = sum[19] ? 16'h8000 : 16'h7FFF;
        end
        return res;
    endfunction

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [15:0] yaw_sin_reg, yaw_cos_reg, tilt_reg;
    logic        [15:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg   <= '0;
            cam_y_reg   <= '0;
            cam_z_reg   <= '0;
            yaw_sin_reg <= '0;
            yaw_cos_reg <= 16'sd16384;
            tilt_reg    <= '0;
            scale_reg   <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_addr)
                cpp_pkg::REG_CAMERA_X:    cam_x_reg   <= cfg_wdata;
                cpp_pkg::REG_CAMERA_Y:    cam_y_reg   <= cfg_wdata;
                cpp_pkg::REG_CAMERA_Z:    cam_z_reg   <= cfg_wdata;
                cpp_pkg::REG_YAW_SINE:    yaw_sin_reg <= cfg_wdata[15:0];
                cpp_pkg::REG_YAW_COSINE:  yaw_cos_reg <= cfg_wdata[15:0];
                cpp_pkg::REG_TILT_FACTOR: tilt_reg    <= cfg_wdata[15:0];
                cpp_pkg::REG_PROJ_SCALE:  scale_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // stage control: a stage advances when empty or when the next one advances
    logic [NS-1:0] vld_reg, vld_next, adv, vld_in;

    assign adv[NS-1] = !vld_reg[NS-1] || m_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign vld_in   = {vld_reg[NS-2:0], s_tvalid};
    assign vld_next = (adv & vld_in) | (~adv & vld_reg);
    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 0: translate, swap axes
    logic signed [32:0] tx_reg, ty_reg, tz_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            tx_reg <= $signed({s_tdata[31], s_tdata[31:0]}) - $signed({cam_x_reg[31], cam_x_reg});
            tz_reg <= $signed({s_tdata[63], s_tdata[63:32]}) - $signed({cam_y_reg[31], cam_y_reg});
            ty_reg <= $signed({s_tdata[95], s_tdata[95:64]}) - $signed({cam_z_reg[31], cam_z_reg});
        end
    end

    // stage 1: yaw products
    logic signed [48:0] xs_reg, zc_reg, xc_reg, zs_reg;
    logic signed [32:0] ty1_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            xs_reg  <= tx_reg * yaw_sin_reg;
            zc_reg  <= tz_reg * yaw_cos_reg;
            xc_reg  <= tx_reg * yaw_cos_reg;
            zs_reg  <= tz_reg * yaw_sin_reg;
            ty1_reg <= ty_reg;
        end
    end

    // stage 2: rotate
    logic signed [49:0] rot_x, rot_z;
    logic signed [35:0] rx_reg, rz_reg;
    logic signed [32:0] ty2_reg;

    assign rot_x = $signed({xs_reg[48], xs_reg}) - $signed({zc_reg[48], zc_reg});
    assign rot_z = $signed({xc_reg[48], xc_reg}) + $signed({zs_reg[48], zs_reg});

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            rx_reg  <= rot_x[49:14];
            rz_reg  <= rot_z[49:14];
            ty2_reg <= ty1_reg;
        end
    end

    // stage 3: tilt product, horizontal scale product
    logic signed [51:0] tp_reg;
    logic signed [52:0] nx3_reg;
    logic signed [35:0] rz3_reg;
    logic signed [32:0] ty3_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            tp_reg  <= rz_reg * tilt_reg;
            nx3_reg <= rx_reg * $signed({1'b0, scale_reg});
            rz3_reg <= rz_reg;
            ty3_reg <= ty2_reg;
        end
    end

    // stage 4: sheared vertical
    logic signed [40:0] ry_reg;
    logic signed [52:0] nx4_reg;
    logic signed [35:0] rz4_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            ry_reg  <= $signed({{8{ty3_reg[32]}}, ty3_reg}) + $signed({tp_reg[51], tp_reg[51:12]});
            nx4_reg <= nx3_reg;
            rz4_reg <= rz3_reg;
        end
    end

    // stage 5: vertical scale product, depth
    logic signed [36:0] den_full;
    logic        [31:0] dep_sat;
    logic signed [57:0] ny5_reg;
    logic signed [52:0] nx5_reg;
    logic signed [35:0] rz5_reg;
    logic               zero5_reg;
    logic        [31:0] dep5_reg;

    assign den_full = -$signed({rz4_reg[35], rz4_reg});

    always_comb begin
        if (den_full[36:31] == {6{den_full[36]}}) begin
            dep_sat = den_full[31:0];
        end else begin
            dep_sat = den_full[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            ny5_reg   <= ry_reg * $signed({1'b0, scale_reg});
            nx5_reg   <= nx4_reg;
            rz5_reg   <= rz4_reg;
            zero5_reg <= (rz4_reg == '0);
            dep5_reg  <= (rz4_reg == '0) ? '0 : dep_sat;
        end
    end

    // stage 6: magnitudes and quotient signs
    logic [52:0]    ax_mag;
    logic [NW-1:0]  ay_mag;
    logic [DW-1:0]  ad_mag;
    logic           den_neg;
    logic [NW-1:0]  mag_x_reg, mag_y_reg;
    cpp_pkg::div_side_t side6_reg;

    assign ax_mag  = nx5_reg[52] ? 53'(-nx5_reg) : 53'(nx5_reg);
    assign ay_mag  = ny5_reg[57] ? NW'(-ny5_reg) : NW'(ny5_reg);
    assign ad_mag  = rz5_reg[35] ? DW'(-rz5_reg) : DW'(rz5_reg);
    assign den_neg = !rz5_reg[35];

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            mag_x_reg         <= NW'(ax_mag);
            mag_y_reg         <= ay_mag;
            side6_reg.den_mag <= ad_mag;
            side6_reg.neg_x   <= nx5_reg[52] ^ den_neg;
            side6_reg.neg_y   <= ny5_reg[57] ^ den_neg;
            side6_reg.ovf_x   <= 1'b0;
            side6_reg.ovf_y   <= 1'b0;
            side6_reg.zero    <= zero5_reg;
            side6_reg.depth   <= dep5_reg;
        end
    end

    // stage 7: range check, then one quotient bit per stage
    logic [NW-1:0]      rem_x_reg [0:QB];
    logic [NW-1:0]      rem_y_reg [0:QB];
    logic [QB-1:0]      q_x_reg   [0:QB];
    logic [QB-1:0]      q_y_reg   [0:QB];
    cpp_pkg::div_side_t side_reg  [0:QB];
    logic [NW-1:0]      den_top;
    cpp_pkg::div_side_t side7;

    assign den_top = NW'(side6_reg.den_mag) << QB;

    always_comb begin
        side7       = side6_reg;
        side7.ovf_x = (mag_x_reg >= den_top);
        side7.ovf_y = (mag_y_reg >= den_top);
    end

    always_ff @(posedge aclk) begin
        if (adv[SD]) begin
            rem_x_reg[0] <= mag_x_reg;
            rem_y_reg[0] <= mag_y_reg;
            q_x_reg[0]   <= '0;
            q_y_reg[0]   <= '0;
            side_reg[0]  <= side7;
        end
    end

    for (genvar d = 0; d < QB; d++) begin : g_div
        logic [NW-1:0] den_sh;
        logic [NW:0]   dif_x, dif_y;

        assign den_sh = NW'(side_reg[d].den_mag) << (QB - 1 - d);
        assign dif_x  = {1'b0, rem_x_reg[d]} - {1'b0, den_sh};
        assign dif_y  = {1'b0, rem_y_reg[d]} - {1'b0, den_sh};

        always_ff @(posedge aclk) begin
            if (adv[SD+1+d]) begin
                rem_x_reg[d+1] <= dif_x[NW] ? rem_x_reg[d] : dif_x[NW-1:0];
                rem_y_reg[d+1] <= dif_y[NW] ? rem_y_reg[d] : dif_y[NW-1:0];
                q_x_reg[d+1]   <= {q_x_reg[d][QB-2:0], ~dif_x[NW]};
                q_y_reg[d+1]   <= {q_y_reg[d][QB-2:0], ~dif_y[NW]};
                side_reg[d+1]  <= side_reg[d];
            end
        end
    end

    // output stage: sign, center offset, saturate
    logic [15:0] sx_reg, sy_reg;
    logic [31:0] dep_out_reg;
    logic        zero_out_reg;

    always_ff @(posedge aclk) begin
        if (adv[NS-1]) begin
            if (side_reg[QB].zero) begin
                sx_reg <= 16'(HALF_WIDTH);
                sy_reg <= 16'(HALF_HEIGHT);
            end else begin
                sx_reg <= screen_sat(q_x_reg[QB], side_reg[QB].neg_x, side_reg[QB].ovf_x,
                                     20'(HALF_WIDTH));
                sy_reg <= screen_sat(q_y_reg[QB], side_reg[QB].neg_y, side_reg[QB].ovf_y,
                                     20'(HALF_HEIGHT));
            end
            dep_out_reg  <= side_reg[QB].depth;
            zero_out_reg <= side_reg[QB].zero;
        end
    end

    assign m_tvalid   = vld_reg[NS-1];
    assign m_tdata    = {dep_out_reg, sy_reg, sx_reg};
    assign m_tuser[0] = zero_out_reg;

endmodule

`default_nettype wire
